/* hdl/vmb_pkg.sv */
// Shared constants and transaction types for the view matrix builder.
`timescale 1ns / 1ps
package vmb_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int NORM_BITS = 30;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_DIR   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic signed [COORD_W-1:0] camera_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] up_x;
    logic signed [COORD_W-1:0] up_y;
    logic signed [COORD_W-1:0] up_z;
  } item_t;

  typedef struct packed {
    logic [1:0]                row_index;
    logic signed [COORD_W-1:0] entry_0;
    logic signed [COORD_W-1:0] entry_1;
    logic signed [COORD_W-1:0] entry_2;
    logic signed [COORD_W-1:0] entry_3;
    logic                      last_row;
    logic                      degenerate;
  } row_t;

endpackage

/* hdl/vmb_norm.sv */
// Pipelined vector normalizer: magnitude, scaling, square root, per-component divide.
`timescale 1ns / 1ps
module vmb_norm #(
  parameter int COORD_WIDTH = vmb_pkg::COORD_W,
  parameter int FRAC_BITS   = vmb_pkg::FRAC_W
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_WIDTH:0] vec [3],
  output logic signed [FRAC_BITS+1:0] unit [3],
  output logic                      ok
);

  localparam int VW  = COORD_WIDTH + 1;
  localparam int NB  = vmb_pkg::NORM_BITS;
  localparam int BLW = $clog2(VW + 1);
  localparam int SQW = 2 * NB + 2;
  localparam int NI  = NB + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int RW  = NB + FRAC_BITS + 1;

  // stage A: magnitudes and largest
  logic [VW-1:0] mag_c [3];
  logic [VW-1:0] mx_c;
  logic [VW-1:0] a_mag [3];
  logic [VW-1:0] a_mx;
  logic [2:0]    a_sgn;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][VW-1] ? (~unsigned'(vec[i]) + VW'(1)) : unsigned'(vec[i]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= mag_c;
      a_mx  <= mx_c;
      for (int i = 0; i < 3; i++) a_sgn[i] <= vec[i][VW-1];
    end
  end

  // stage B: bit length of largest
  logic [BLW-1:0] bl_c;
  logic [VW-1:0]  b_mag [3];
  logic [2:0]     b_sgn;
  logic [BLW-1:0] b_bl;
  logic           b_zero;

  always_comb begin
    bl_c = '0;
    for (int i = 0; i < VW; i++) begin
      if (a_mx[i]) bl_c = BLW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag  <= a_mag;
      b_sgn  <= a_sgn;
      b_bl   <= bl_c;
      b_zero <= (a_mx == '0);
    end
  end

  // stage C: common shift so the largest has NB significant bits
  logic [NB-1:0] sh_c [3];
  logic [NB-1:0] c_a [3];
  logic [2:0]    c_sgn;
  logic          c_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_bl > BLW'(NB))
        sh_c[i] = NB'(b_mag[i] >> (b_bl - BLW'(NB)));
      else
        sh_c[i] = NB'({{NB{1'b0}}, b_mag[i]} << (BLW'(NB) - b_bl));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a    <= sh_c;
      c_sgn  <= b_sgn;
      c_zero <= b_zero;
    end
  end

  // stage D: squares
  logic [2*NB-1:0] d_sq [3];
  logic [NB-1:0]   d_a [3];
  logic [2:0]      d_sgn;
  logic            d_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_sq[i] <= {{NB{1'b0}}, c_a[i]} * {{NB{1'b0}}, c_a[i]};
      end
      d_a    <= c_a;
      d_sgn  <= c_sgn;
      d_zero <= c_zero;
    end
  end

  // stage E: sum of squares feeds the root pipeline
  logic [SQW-1:0] s_rem  [0:NI];
  logic [SQW-1:0] s_res  [0:NI];
  logic [NB-1:0]  s_a    [0:NI][3];
  logic [2:0]     s_sgn  [0:NI];
  logic           s_zero [0:NI];

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem[0]  <= SQW'(d_sq[0]) + SQW'(d_sq[1]) + SQW'(d_sq[2]);
      s_res[0]  <= '0;
      s_a[0]    <= d_a;
      s_sgn[0]  <= d_sgn;
      s_zero[0] <= d_zero;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < NI; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NI - 1 - k));
    logic [SQW:0]   trial;
    logic [SQW-1:0] rem_next;
    logic [SQW-1:0] res_next;

    always_comb begin
      trial = {1'b0, s_res[k]} + {1'b0, BIT};
      if ({1'b0, s_rem[k]} >= trial) begin
        rem_next = s_rem[k] - trial[SQW-1:0];
        res_next = (s_res[k] >> 1) + BIT;
      end else begin
        rem_next = s_rem[k];
        res_next = s_res[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k+1]  <= rem_next;
        s_res[k+1]  <= res_next;
        s_a[k+1]    <= s_a[k];
        s_sgn[k+1]  <= s_sgn[k];
        s_zero[k+1] <= s_zero[k];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  logic [RW-1:0] v_rem  [0:QW][3];
  logic [QW-1:0] v_q    [0:QW][3];
  logic [NI-1:0] v_len  [0:QW];
  logic [2:0]    v_sgn  [0:QW];
  logic          v_zero [0:QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_rem[0][i] = RW'(s_a[NI][i]) << FRAC_BITS;
      v_q[0][i]   = '0;
    end
    v_len[0]  = s_res[NI][NI-1:0];
    v_sgn[0]  = s_sgn[NI];
    v_zero[0] = s_zero[NI];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] cmp;
    logic [RW-1:0] rem_next [3];
    logic [QW-1:0] q_next   [3];

    always_comb begin
      cmp = RW'(v_len[j]) << (QW - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (v_rem[j][i] >= cmp) begin
          rem_next[i] = v_rem[j][i] - cmp;
          q_next[i]   = {v_q[j][i][QW-2:0], 1'b1};
        end else begin
          rem_next[i] = v_rem[j][i];
          q_next[i]   = {v_q[j][i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_rem[j+1]  <= rem_next;
        v_q[j+1]    <= q_next;
        v_len[j+1]  <= v_len[j];
        v_sgn[j+1]  <= v_sgn[j];
        v_zero[j+1] <= v_zero[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit[i] = v_sgn[QW][i] ? -signed'({1'b0, v_q[QW][i]}) : signed'({1'b0, v_q[QW][i]});
    end
    ok = !v_zero[QW];
  end

endmodule

/* hdl/vmb_post.sv */
// Cross product, row saturation and translation pipeline.
`timescale 1ns / 1ps
module vmb_post #(
  parameter int COORD_WIDTH = vmb_pkg::COORD_W,
  parameter int FRAC_BITS   = vmb_pkg::FRAC_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [FRAC_BITS+1:0]   u [3],
  input  logic signed [FRAC_BITS+1:0]   d [3],
  input  logic                          ok,
  input  logic signed [COORD_WIDTH-1:0] cam [3],
  output logic                          out_vld,
  output logic signed [COORD_WIDTH-1:0] ent [0:2][0:3],
  output logic                          dgn
);

  localparam int CW   = COORD_WIDTH;
  localparam int UW   = FRAC_BITS + 2;
  localparam int PW   = 2 * UW;
  localparam int TW   = 2 * CW + 2;
  localparam int BIGW = 2 * CW + 2 * FRAC_BITS + 8;
  localparam logic signed [BIGW-1:0] SAT_HI = (BIGW'(1) << (CW - 1)) - BIGW'(1);
  localparam logic signed [BIGW-1:0] SAT_LO = -SAT_HI - BIGW'(1);

  function automatic logic signed [CW-1:0] sat(input logic signed [BIGW-1:0] x);
    logic signed [CW-1:0] y;
    if (x > SAT_HI)      y = SAT_HI[CW-1:0];
    else if (x < SAT_LO) y = SAT_LO[CW-1:0];
    else                 y = x[CW-1:0];
    return y;
  endfunction

  // P1: six cross-product terms
  logic                 p1_vld;
  logic signed [PW-1:0] p1_pr [6];
  logic signed [UW-1:0] p1_u [3];
  logic signed [UW-1:0] p1_d [3];
  logic                 p1_ok;
  logic signed [CW-1:0] p1_cam [3];

  always_ff @(posedge clk) begin
    if (rst) p1_vld <= 1'b0;
    else if (en) p1_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pr[0] <= PW'(u[1]) * PW'(d[2]);
      p1_pr[1] <= PW'(u[2]) * PW'(d[1]);
      p1_pr[2] <= PW'(u[2]) * PW'(d[0]);
      p1_pr[3] <= PW'(u[0]) * PW'(d[2]);
      p1_pr[4] <= PW'(u[0]) * PW'(d[1]);
      p1_pr[5] <= PW'(u[1]) * PW'(d[0]);
      p1_u     <= u;
      p1_d     <= d;
      p1_ok    <= ok;
      p1_cam   <= cam;
    end
  end

  // P2: right vector with floor shift, all rows saturated
  logic signed [PW:0]   diff_c [3];
  logic signed [CW-1:0] p2_row [0:2][0:2];
  logic                 p2_vld;
  logic                 p2_ok;
  logic signed [CW-1:0] p2_cam [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = ((PW+1)'(p1_pr[2*i]) - (PW+1)'(p1_pr[2*i+1])) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p2_vld <= 1'b0;
    else if (en) p2_vld <= p1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_row[0][i] <= sat(BIGW'(diff_c[i]));
        p2_row[1][i] <= sat(BIGW'(p1_u[i]));
        p2_row[2][i] <= sat(BIGW'(p1_d[i]));
      end
      p2_ok  <= p1_ok;
      p2_cam <= p1_cam;
    end
  end

  // P3: row times camera products
  logic signed [2*CW-1:0] p3_pr  [0:2][0:2];
  logic signed [CW-1:0]   p3_row [0:2][0:2];
  logic                   p3_vld;
  logic                   p3_ok;

  always_ff @(posedge clk) begin
    if (rst) p3_vld <= 1'b0;
    else if (en) p3_vld <= p2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p3_pr[k][i] <= (2*CW)'(p2_row[k][i]) * (2*CW)'(p2_cam[i]);
        end
      end
      p3_row <= p2_row;
      p3_ok  <= p2_ok;
    end
  end

  // P4: translation = -floor(sum / 2^F), saturated; degenerate rows cleared
  logic signed [TW-1:0] sum_c [3];
  logic signed [TW:0]   neg_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = (TW'(p3_pr[k][0]) + TW'(p3_pr[k][1]) + TW'(p3_pr[k][2])) >>> FRAC_BITS;
      neg_c[k] = -(TW+1)'(sum_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= p3_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          ent[k][i] <= p3_ok ? p3_row[k][i] : '0;
        end
        ent[k][3] <= p3_ok ? sat(BIGW'(neg_c[k])) : '0;
      end
      dgn <= !p3_ok;
    end
  end

endmodule

/* hdl/vmb_rows.sv */
// Output register that hands out the three rows of one matrix in turn.
`timescale 1ns / 1ps
module vmb_rows #(
  parameter int COORD_WIDTH = vmb_pkg::COORD_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [COORD_WIDTH-1:0] ent [0:2][0:3],
  input  logic                          dgn,
  output logic                          ready,
  output logic                          row_valid,
  input  logic                          row_stall,
  output vmb_pkg::row_t                 row
);

  localparam int OW = vmb_pkg::COORD_W;

  logic                          busy;
  logic [1:0]                    cnt;
  logic signed [COORD_WIDTH-1:0] hold [0:2][0:3];
  logic                          hold_dgn;

  assign ready     = !busy || (cnt == vmb_pkg::ROW_DIR && !row_stall);
  assign row_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= vmb_pkg::ROW_RIGHT;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= vmb_pkg::ROW_RIGHT;
    end else if (busy && !row_stall) begin
      if (cnt == vmb_pkg::ROW_DIR) busy <= 1'b0;
      else cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold     <= ent;
      hold_dgn <= dgn;
    end
  end

  always_comb begin
    row.row_index  = cnt;
    row.entry_0    = OW'(hold[0][0]);
    row.entry_1    = OW'(hold[0][1]);
    row.entry_2    = OW'(hold[0][2]);
    row.entry_3    = OW'(hold[0][3]);
    case (cnt)
      vmb_pkg::ROW_UP: begin
        row.entry_0 = OW'(hold[1][0]);
        row.entry_1 = OW'(hold[1][1]);
        row.entry_2 = OW'(hold[1][2]);
        row.entry_3 = OW'(hold[1][3]);
      end
      vmb_pkg::ROW_DIR: begin
        row.entry_0 = OW'(hold[2][0]);
        row.entry_1 = OW'(hold[2][1]);
        row.entry_2 = OW'(hold[2][2]);
        row.entry_3 = OW'(hold[2][3]);
      end
      default: begin
      end
    endcase
    row.last_row   = (cnt == vmb_pkg::ROW_DIR);
    row.degenerate = hold_dgn;
  end

endmodule

/* hdl/view_matrix_builder_top.sv */
// Top level of the look-at view matrix builder.
`timescale 1ns / 1ps
// Usage:
//   Input channel (item_valid / item_stall / item): one transaction carries the
//   camera position, target point and up vector, signed fixed point.
//   Output channel (row_valid / row_stall / row): three transactions per item,
//   rows right, up and direction in that order; last_row marks the third.
//   Entry 3 of each row is minus the row dotted with the camera, saturated.
//   A zero-length up or direction vector gives degenerate = 1 and zero entries.
// Timing:
//   One pipeline advances as a whole: input register, normalizer (5 setup
//   stages, NORM_BITS+1 square-root stages, FRAC_BITS+1 divide stages), four
//   post stages, then the row register.
//   Throughput is set by the output, one row per cycle while row_stall is low;
//   items may arrive back to back and queue in the pipeline.
// Reset clears all valid bits and the row counter and busy flag; nothing else needs clearing.
// A stalled receiver freezes the row on the port; when a valid post output
// waits on a busy row register, the whole pipeline holds and item_stall rises.
module view_matrix_builder_top #(
  parameter int COORD_WIDTH = vmb_pkg::COORD_W,
  parameter int FRAC_BITS   = vmb_pkg::FRAC_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  vmb_pkg::item_t item,
  output logic           row_valid,
  input  logic           row_stall,
  output vmb_pkg::row_t  row
);

  localparam int CW = COORD_WIDTH;
  localparam int VW = CW + 1;
  localparam int UW = FRAC_BITS + 2;
  // normalizer depth, must match vmb_norm
  localparam int NL = 5 + (vmb_pkg::NORM_BITS + 1) + (FRAC_BITS + 1);

  logic adv;          // whole pipeline moves
  logic rows_ready;   // row register can take a new matrix
  logic post_vld;

  assign adv        = !post_vld || rows_ready;
  assign item_stall = !adv;

  // input register: camera, direction (exact difference), up
  logic                 s0_vld;
  logic signed [CW-1:0] s0_cam [3];
  logic signed [VW-1:0] s0_dir [3];
  logic signed [VW-1:0] s0_up  [3];

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else if (adv) s0_vld <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cam[0] <= CW'(item.camera_x);
      s0_cam[1] <= CW'(item.camera_y);
      s0_cam[2] <= CW'(item.camera_z);
      s0_dir[0] <= VW'(item.target_x) - VW'(item.camera_x);
      s0_dir[1] <= VW'(item.target_y) - VW'(item.camera_y);
      s0_dir[2] <= VW'(item.target_z) - VW'(item.camera_z);
      s0_up[0]  <= VW'(item.up_x);
      s0_up[1]  <= VW'(item.up_y);
      s0_up[2]  <= VW'(item.up_z);
    end
  end

  // both vectors normalized side by side
  logic signed [UW-1:0] u_unit [3];
  logic signed [UW-1:0] d_unit [3];
  logic                 u_ok;
  logic                 d_ok;

  vmb_norm #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk  (clk),
    .en   (adv),
    .vec  (s0_up),
    .unit (u_unit),
    .ok   (u_ok)
  );

  vmb_norm #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_norm_dir (
    .clk  (clk),
    .en   (adv),
    .vec  (s0_dir),
    .unit (d_unit),
    .ok   (d_ok)
  );

  // valid bits and camera ride alongside the normalizers
  logic                 vld_line [0:NL];
  logic signed [CW-1:0] cam_line [0:NL][3];

  always_comb begin
    vld_line[0] = s0_vld;
    cam_line[0] = s0_cam;
  end

  for (genvar k = 0; k < NL; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) vld_line[k+1] <= 1'b0;
      else if (adv) vld_line[k+1] <= vld_line[k];
    end

    always_ff @(posedge clk) begin
      if (adv) cam_line[k+1] <= cam_line[k];
    end
  end

  // cross product and translation
  logic signed [CW-1:0] ent [0:2][0:3];
  logic                 dgn;

  vmb_post #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_post (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (vld_line[NL]),
    .u       (u_unit),
    .d       (d_unit),
    .ok      (u_ok && d_ok),
    .cam     (cam_line[NL]),
    .out_vld (post_vld),
    .ent     (ent),
    .dgn     (dgn)
  );

  // row register: one matrix at a time, one row per transaction
  vmb_rows #(.COORD_WIDTH(COORD_WIDTH)) u_rows (
    .clk       (clk),
    .rst       (rst),
    .load      (adv && post_vld),
    .ent       (ent),
    .dgn       (dgn),
    .ready     (rows_ready),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row       (row)
  );

endmodule

/* test/view_matrix_builder_top_test.sv */
// Self-checking testbench for the look-at view matrix builder.
`timescale 1ns / 1ps
module view_matrix_builder_top_test;

  typedef longint vec3_t [3];

  // Predicts the three rows for each accepted item and checks them in order.
  class row_scoreboard;
    vmb_pkg::row_t pending_rows[$];
    int     errors;
    int     items_seen;
    int     rows_seen;
    int     degenerate_seen;

    function new();
      errors = 0;
      items_seen = 0;
      rows_seen = 0;
      degenerate_seen = 0;
    endfunction

    static function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Truncated unit vector; returns 0 for the zero vector.
    static function bit unit_vec(input vec3_t v, output vec3_t o);
      longint unsigned a [3];
      longint unsigned m, sq, len, q;
      int bl;
      m = 0;
      sq = 0;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
        if (a[i] > m) m = a[i];
      end
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (m == 0) return 0;
      while (bl < 64 && (m >> bl) != 0) bl++;
      for (int i = 0; i < 3; i++) begin
        if (bl > vmb_pkg::NORM_BITS) a[i] = a[i] >> (bl - vmb_pkg::NORM_BITS);
        else a[i] = a[i] << (vmb_pkg::NORM_BITS - bl);
        sq += a[i] * a[i];
      end
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (a[i] << vmb_pkg::FRAC_W) / len;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    // -(row . camera), exact floor of the scaled sum, then clamped
    static function longint offset(vec3_t r, vec3_t cam);
      longint hi, lo;
      hi = 0;
      lo = 0;
      for (int i = 0; i < 3; i++) begin
        hi += r[i] * (cam[i] >>> vmb_pkg::FRAC_W);
        lo += r[i] * (cam[i] & 64'hFFFF);
      end
      return clamp(-(hi + (lo >>> vmb_pkg::FRAC_W)));
    endfunction

    function void note_item(vmb_pkg::item_t it);
      vec3_t cam, dir, upv, u, d, rgt;
      vec3_t rows [3];
      bit ok_u, ok_d, ok;
      vmb_pkg::row_t r;
      cam = '{longint'(it.camera_x), longint'(it.camera_y), longint'(it.camera_z)};
      dir = '{longint'(it.target_x) - cam[0], longint'(it.target_y) - cam[1],
              longint'(it.target_z) - cam[2]};
      upv = '{longint'(it.up_x), longint'(it.up_y), longint'(it.up_z)};
      ok_u = unit_vec(upv, u);
      ok_d = unit_vec(dir, d);
      ok = ok_u && ok_d;
      rgt[0] = clamp((u[1] * d[2] - u[2] * d[1]) >>> vmb_pkg::FRAC_W);
      rgt[1] = clamp((u[2] * d[0] - u[0] * d[2]) >>> vmb_pkg::FRAC_W);
      rgt[2] = clamp((u[0] * d[1] - u[1] * d[0]) >>> vmb_pkg::FRAC_W);
      for (int i = 0; i < 3; i++) begin
        rows[0][i] = rgt[i];
        rows[1][i] = clamp(u[i]);
        rows[2][i] = clamp(d[i]);
      end
      items_seen++;
      if (!ok) degenerate_seen++;
      for (int k = 0; k < 3; k++) begin
        r = '0;
        r.row_index = (k == 0) ? vmb_pkg::ROW_RIGHT :
                      (k == 1) ? vmb_pkg::ROW_UP : vmb_pkg::ROW_DIR;
        if (ok) begin
          r.entry_0 = rows[k][0][31:0];
          r.entry_1 = rows[k][1][31:0];
          r.entry_2 = rows[k][2][31:0];
          r.entry_3 = 32'(offset(rows[k], cam));
        end
        r.last_row = (k == 2);
        r.degenerate = !ok;
        pending_rows.push_back(r);
      end
    endfunction

    function void check_row(vmb_pkg::row_t got);
      vmb_pkg::row_t exp;
      rows_seen++;
      if (pending_rows.size() == 0) begin
        $error("row transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = pending_rows.pop_front();
      if (got.row_index !== exp.row_index) begin
        $error("row_index exp %0d got %0d", exp.row_index, got.row_index);
        errors++;
      end
      if (got.entry_0 !== exp.entry_0) begin
        $error("entry_0 exp %0d got %0d", exp.entry_0, got.entry_0);
        errors++;
      end
      if (got.entry_1 !== exp.entry_1) begin
        $error("entry_1 exp %0d got %0d", exp.entry_1, got.entry_1);
        errors++;
      end
      if (got.entry_2 !== exp.entry_2) begin
        $error("entry_2 exp %0d got %0d", exp.entry_2, got.entry_2);
        errors++;
      end
      if (got.entry_3 !== exp.entry_3) begin
        $error("entry_3 exp %0d got %0d", exp.entry_3, got.entry_3);
        errors++;
      end
      if (got.last_row !== exp.last_row) begin
        $error("last_row exp %0d got %0d", exp.last_row, got.last_row);
        errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $error("degenerate exp %0d got %0d", exp.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 40000;

  logic           clk;
  logic           rst;
  logic           item_valid;
  logic           item_stall;
  vmb_pkg::item_t item;
  logic           row_valid;
  logic           row_stall;
  vmb_pkg::row_t  row;

  row_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit finished;

  view_matrix_builder_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .row_valid  (row_valid),
    .row_stall  (row_stall),
    .row        (row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stall, check each accepted row transaction.
  always @(posedge clk) begin
    if (!rst && row_valid && !row_stall) sb.check_row(row);
    row_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (row_valid && !row_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!finished && quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("view_matrix_builder_top: mismatch");
      $finish;
    end
  end

  // Drive one item; idle cycles come before raising valid, never after.
  task automatic send_item(vmb_pkg::item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic drop_valid_and_drain();
    item_valid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
  endtask

  function automatic vmb_pkg::item_t make_item(longint cx, longint cy, longint cz,
                                               longint tx, longint ty, longint tz,
                                               longint ux, longint uy, longint uz);
    vmb_pkg::item_t it;
    it = '{cx[31:0], cy[31:0], cz[31:0], tx[31:0], ty[31:0], tz[31:0],
           ux[31:0], uy[31:0], uz[31:0]};
    return it;
  endfunction

  // Mostly sensible scenes in a modest range, some full-range noise.
  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
    endcase
  endfunction

  function automatic vmb_pkg::item_t rand_item();
    vmb_pkg::item_t it;
    int mode;
    int pick;
    mode = $urandom_range(0, 5);
    if (mode > 2) mode = 1;
    it = '{rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    pick = $urandom_range(0, 29);
    if (pick == 0) {it.up_x, it.up_y, it.up_z} = '0;
    if (pick == 1) {it.target_x, it.target_y, it.target_z} =
                   {it.camera_x, it.camera_y, it.camera_z};
    if (pick == 2) {it.up_x, it.up_y, it.up_z} = {32'h0, 32'h0001_0000, 32'h0};
    return it;
  endfunction

  vmb_pkg::item_t directed [$];

  initial begin
    sb = new();
    finished = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    send_idle_pct = 35;
    recv_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: standard view, axes, degenerate cases, extremes.
    directed.push_back(make_item(0, 0, 0, 0, 0, -65536, 0, 65536, 0));
    directed.push_back(make_item(65536, 131072, 196608, 0, 0, 0, 0, 65536, 0));
    directed.push_back(make_item(0, 0, 0, 65536, 0, 0, 0, 0, 65536));
    directed.push_back(make_item(1, 2, 3, 4, 5, 6, 0, 0, 0));
    directed.push_back(make_item(7, 8, 9, 7, 8, 9, 0, 1, 0));
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(0, 0, 0, 0, 0, 1, 1, 0, 0));
    directed.push_back(make_item(-2147483648, -2147483648, -2147483648,
                                 2147483647, 2147483647, 2147483647,
                                 -2147483648, -2147483648, -2147483648));
    directed.push_back(make_item(2147483647, 2147483647, 2147483647,
                                 -2147483648, -2147483648, -2147483648,
                                 2147483647, 2147483647, 2147483647));
    directed.push_back(make_item(2147483647, -2147483648, 2147483647,
                                 0, 0, 0, -1, -1, -1));
    directed.push_back(make_item(-2147483648, 0, 0, -2147483647, 0, 0,
                                 0, -2147483648, 0));
    directed.push_back(make_item(2147483647, 2147483647, 0, 2147483647, 0, 0,
                                 1, 1, 1));
    directed.push_back(make_item(-1, -1, -1, 0, 0, 0, 2147483647, 0, -2147483648));
    directed.push_back(make_item(100, -200, 300, -400, 500, -600, 3, -5, 7));
    directed.push_back(make_item(0, 65536, 0, 0, 65536, 0, 0, 65536, 0));
    directed.push_back(make_item(65536, 0, 0, 65536, 0, 65536, 65536, 0, 0));
    foreach (directed[i]) send_item(directed[i]);

    for (int n = 0; n < 65; n++) send_item(rand_item());

    // Let the pipeline empty completely before swapping the idle pattern.
    drop_valid_and_drain();
    send_idle_pct = 87;
    recv_idle_pct = 35;
    for (int n = 0; n < 70; n++) send_item(rand_item());

    drop_valid_and_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 70; n++) send_item(rand_item());

    drop_valid_and_drain();
    repeat (100) @(posedge clk);
    finished = 1;

    $display("covered %0d items (%0d degenerate), %0d row transactions checked",
             sb.items_seen, sb.degenerate_seen, sb.rows_seen);
    if (sb.errors == 0 && sb.pending_rows.size() == 0)
      $display("view_matrix_builder_top: match");
    else
      $display("view_matrix_builder_top: mismatch");
    $finish;
  end

endmodule
